// ===== rtl/core/bpda_pkg.sv =====
`timescale 1ns / 1ps

package bpda_pkg;

  // a 16-bit value has at most five decimal digits
  localparam int unsigned ValueDigits = 5;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNul  = 8'h00;

  typedef logic [3:0] digit_t;
  typedef digit_t [ValueDigits-1:0] digits_t;

  typedef struct packed {
    logic [15:0] value;
    logic [3:0]  min_digits;
  } in_t;

  typedef struct packed {
    logic [7:0] character;
    logic [3:0] text_length;
    logic       last;
  } out_t;

endpackage

// ===== rtl/core/bpda_bcd_pipe.sv =====
`timescale 1ns / 1ps

module bpda_bcd_pipe #(
  parameter int MAX_DIGITS = 8,
  localparam int LenW = $clog2(MAX_DIGITS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bpda_pkg::in_t    in_i,
  output logic             conv_valid_o,
  input  logic             conv_ready_i,
  output bpda_pkg::digits_t conv_digits_o,
  output logic [LenW-1:0]  conv_len_o
);

  import bpda_pkg::*;

  localparam int Stages = ValueDigits - 1;
  // x * 0xcccd >> 19 equals x / 10 for every 16-bit x
  localparam logic [16:0] RecipMul   = 17'h0cccd;
  localparam int          RecipShift = 19;

  typedef struct packed {
    logic [15:0] quo;
    digit_t      rem;
  } div_t;

  function automatic div_t div10(input logic [15:0] x);
    logic [32:0] prod;
    logic [15:0] q;
    logic [15:0] back;
    div_t        r;
    prod   = {17'd0, x} * {16'd0, RecipMul};
    q      = 16'(prod >> RecipShift);
    back   = 16'(q << 3) + 16'(q << 1);
    r.quo  = q;
    r.rem  = 4'(x - back);
    return r;
  endfunction

  logic [Stages-1:0]       vld_q;
  logic [15:0]             rem_q  [Stages];
  digits_t                 digs_q [Stages];
  logic [LenW-1:0]         len_q  [Stages];
  logic [Stages:0]         rdy;

  // length of the text, worked out on entry
  logic [2:0]      ndig;
  logic [LenW-1:0] min_clamp;
  logic [LenW-1:0] len_in;

  always_comb begin
    if (in_i.value >= 16'd10000) begin
      ndig = 3'd5;
    end else if (in_i.value >= 16'd1000) begin
      ndig = 3'd4;
    end else if (in_i.value >= 16'd100) begin
      ndig = 3'd3;
    end else if (in_i.value >= 16'd10) begin
      ndig = 3'd2;
    end else if (in_i.value != 16'd0) begin
      ndig = 3'd1;
    end else begin
      ndig = 3'd0;
    end
    if (32'(in_i.min_digits) > MAX_DIGITS) begin
      min_clamp = LenW'(MAX_DIGITS);
    end else begin
      min_clamp = LenW'(in_i.min_digits);
    end
    len_in = (LenW'(ndig) > min_clamp) ? LenW'(ndig) : min_clamp;
  end

  assign rdy[Stages] = conv_ready_i;

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic [15:0]     src_rem;
    digits_t         src_digs;
    logic [LenW-1:0] src_len;
    logic            src_vld;
    div_t            dv;
    digits_t         digs_d;

    assign rdy[k] = !vld_q[k] || rdy[k+1];

    if (k == 0) begin : g_first
      assign src_rem  = in_i.value;
      assign src_digs = '0;
      assign src_len  = len_in;
      assign src_vld  = in_valid_i;
    end else begin : g_next
      assign src_rem  = rem_q[k-1];
      assign src_digs = digs_q[k-1];
      assign src_len  = len_q[k-1];
      assign src_vld  = vld_q[k-1];
    end

    always_comb begin
      dv        = div10(src_rem);
      digs_d    = src_digs;
      digs_d[k] = dv.rem;
      // the last quotient is the top digit
      if (k == Stages - 1) begin
        digs_d[ValueDigits-1] = dv.quo[3:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && src_vld) begin
        rem_q[k]  <= dv.quo;
        digs_q[k] <= digs_d;
        len_q[k]  <= src_len;
      end
    end
  end

  assign in_ready_o    = rdy[0];
  assign conv_valid_o  = vld_q[Stages-1];
  assign conv_digits_o = digs_q[Stages-1];
  assign conv_len_o    = len_q[Stages-1];

endmodule

// ===== rtl/core/binary_to_padded_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps

// Converts a 16-bit unsigned value to decimal ASCII, most significant digit first,
// padded with leading '0' up to min_digits (clamped to MAX_DIGITS), then a NUL marked
// last; every result carries the text length. An item is taken when start_i is high
// and busy_o is low. A four-stage divide-by-ten pipeline feeds a character emitter, whose
// registered output drives out_o. Results leave one per cycle on out_o, each valid only
// in the cycle strobe_o is high; the receiver cannot hold them off. The single character
// port sets the sustained rate: an item holds the port for its digits and then its NUL,
// and up to four further items queue in the pipeline while a text is being sent.
module binary_to_padded_decimal_ascii_unit #(
  parameter int MAX_DIGITS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  bpda_pkg::in_t  in_i,
  output logic           strobe_o,
  output bpda_pkg::out_t out_o
);

  import bpda_pkg::*;

  localparam int LenW = $clog2(MAX_DIGITS + 1);

  logic            conv_valid;
  logic            conv_ready;
  digits_t         conv_digits;
  logic [LenW-1:0] conv_len;
  logic            in_ready;

  bpda_bcd_pipe #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (start_i),
    .in_ready_o   (in_ready),
    .in_i         (in_i),
    .conv_valid_o (conv_valid),
    .conv_ready_i (conv_ready),
    .conv_digits_o(conv_digits),
    .conv_len_o   (conv_len)
  );

  assign busy_o = !in_ready;

  // emitter: counts down the characters still to send
  logic            act_q, act_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] len_q;
  digits_t         digs_q;
  logic            strobe_q;
  out_t            out_q, out_d;
  logic [LenW-1:0] idx;
  digit_t          sel_digit;

  assign conv_ready = !act_q || (cnt_q == '0);

  always_comb begin
    idx       = cnt_q - LenW'(1);
    // positions above the top digit are padding
    sel_digit = (idx < LenW'(ValueDigits)) ? digs_q[idx[2:0]] : '0;

    out_d.text_length = 4'(len_q);
    if (cnt_q == '0) begin
      out_d.character = AsciiNul;
      out_d.last      = 1'b1;
    end else begin
      out_d.character = AsciiZero + {4'd0, sel_digit};
      out_d.last      = 1'b0;
    end

    act_d = act_q;
    cnt_d = cnt_q;
    if (act_q && (cnt_q != '0)) begin
      cnt_d = cnt_q - LenW'(1);
    end else if (conv_valid) begin
      act_d = 1'b1;
      cnt_d = conv_len;
    end else begin
      act_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      act_q    <= act_d;
      cnt_q    <= cnt_d;
      strobe_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_ready && conv_valid) begin
      digs_q <= conv_digits;
      len_q  <= conv_len;
    end
    if (act_q) begin
      out_q <= out_d;
    end
  end

  assign strobe_o = strobe_q;
  assign out_o    = out_q;

  // a text is sent without gaps up to its terminator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !out_o.last) |=> strobe_o)
    else $error("gap inside a text");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !out_o.last) |=> (out_o.text_length == $past(out_o.text_length)))
    else $error("text length changed within a text");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !out_o.last) |->
      (out_o.character >= AsciiZero && out_o.character <= (AsciiZero + 8'd9)))
    else $error("non-digit character before terminator");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && out_o.last) |-> (out_o.character == AsciiNul))
    else $error("terminator is not nul");

endmodule
